### src/stereo_expander_gain_stage_top_assert.svh
// Assertion macros for the stereo expander gain stage top level.
// Needs clk and rst_n in the including scope; no other dependencies.
`ifndef STEREO_EXPANDER_GAIN_STAGE_TOP_ASSERT_SVH
`define STEREO_EXPANDER_GAIN_STAGE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SEG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/seg_pkg.sv
// Shared types, constants, command codes and helper functions for the
// stereo expander gain stage. No dependencies.
package seg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TBL_D    = 256;
  localparam int TBL_AW   = $clog2(TBL_D);
  localparam int LVL_SH   = 24 - SAMPLE_W;
  localparam int FOL_SH   = 25 - SAMPLE_W;

  // shared multiplier operand and product widths
  localparam int MA_W = 25;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;

  localparam int SAT_W = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  typedef logic [24:0] q24_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [0:TBL_D-1][24:0] pow2_tbl_t;

  localparam q24_t ONE_Q24   = 25'd16777216;
  localparam q24_t LOG2E_Q24 = 25'd24204406;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam logic signed [SAT_W-1:0] S_MAX = SAT_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic signed [SAT_W-1:0] S_MIN = -S_MAX - SAT_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_FAC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LEVEL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOWER    = 3'd7;

  // reset values
  localparam q24_t        RST_THR_LEVEL   = 25'd16777216;
  localparam logic [32:0] RST_THR_GAIN    = 33'd65536;
  localparam logic [21:0] RST_SHAPE_FAC   = 22'd65536;
  localparam q24_t        RST_SHAPE_FLOOR = 25'd6171993;
  localparam q24_t        RST_ATTACK      = 25'd1398;
  localparam q24_t        RST_DECAY       = 25'd13981;
  localparam logic [19:0] RST_OUT_LEVEL   = 20'd65536;

  // datapath operation codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
  localparam logic [OP_W-1:0] OP_ENV_MUL = 5'd1;
  localparam logic [OP_W-1:0] OP_ENV_UPD = 5'd2;
  localparam logic [OP_W-1:0] OP_U_MUL   = 5'd3;
  localparam logic [OP_W-1:0] OP_U_UPD   = 5'd4;
  localparam logic [OP_W-1:0] OP_T_MUL   = 5'd5;
  localparam logic [OP_W-1:0] OP_T_UPD   = 5'd6;
  localparam logic [OP_W-1:0] OP_Z_MUL   = 5'd7;
  localparam logic [OP_W-1:0] OP_Z_UPD   = 5'd8;
  localparam logic [OP_W-1:0] OP_TBL     = 5'd9;
  localparam logic [OP_W-1:0] OP_I_MUL   = 5'd10;
  localparam logic [OP_W-1:0] OP_I_UPD   = 5'd11;
  localparam logic [OP_W-1:0] OP_SHAPE   = 5'd12;
  localparam logic [OP_W-1:0] OP_S_MUL   = 5'd13;
  localparam logic [OP_W-1:0] OP_S_UPD   = 5'd14;
  localparam logic [OP_W-1:0] OP_G_MUL   = 5'd15;
  localparam logic [OP_W-1:0] OP_G_UPD   = 5'd16;
  localparam logic [OP_W-1:0] OP_L_MUL   = 5'd17;
  localparam logic [OP_W-1:0] OP_L_UPD   = 5'd18;
  localparam logic [OP_W-1:0] OP_R_MUL   = 5'd19;
  localparam logic [OP_W-1:0] OP_R_UPD   = 5'd20;
  localparam logic [OP_W-1:0] OP_FOL     = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            capture;
    logic            ld_out;
  } cmd_t;

  typedef struct packed {
    logic follower;
  } status_t;

  // quotient of a value below 2^31 by a small count, shift and subtract
  function automatic logic [63:0] div_small(input logic [63:0] num, input logic [4:0] den);
    logic [63:0] q;
    logic [5:0]  rem;
    int          i;
    q   = '0;
    rem = '0;
    for (i = 30; i >= 0; i--) begin
      rem = {rem[4:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^(-k/TBL_D) in Q0.24 through a 16-term series for e^-a in Q2.30
  function automatic q24_t pow2_entry(input int k);
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    int n;
    x = 64'(k) << (30 - TBL_AW);
    a = (x * LN2_Q30 + (64'd1 << 29)) >> 30;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (n = 1; n <= 16; n++) begin
      term = div_small((term * a) >> 30, 5'(n));
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    return 25'((sum + 64'd32) >> 6);
  endfunction

  function automatic pow2_tbl_t gen_pow2_tbl();
    pow2_tbl_t t;
    int k;
    for (k = 0; k < TBL_D; k++) t[k] = pow2_entry(k);
    return t;
  endfunction

  localparam pow2_tbl_t POW2_TBL  = gen_pow2_tbl();
  localparam q24_t      POW2_LAST = pow2_entry(TBL_D);

  // round half up, then shift right by a constant amount (sh >= 1)
  function automatic logic [MP_W-1:0] rnd_shr(input logic [MP_W-1:0] p, input int sh);
    logic [MP_W:0] w;
    w = {1'b0, p} + ((MP_W+1)'(1) << (sh - 1));
    return MP_W'(w >> sh);
  endfunction

  function automatic sample_t sat_s(input logic signed [SAT_W-1:0] v);
    if (v > S_MAX) return SAMPLE_W'(S_MAX);
    if (v < S_MIN) return SAMPLE_W'(S_MIN);
    return SAMPLE_W'(v);
  endfunction

  function automatic q24_t clamp_rate(input q24_t r);
    return (r > ONE_Q24) ? ONE_Q24 : r;
  endfunction

endpackage

### src/seg_if.sv
// Valid/ready stream interfaces for the sample and result channels.
// Depends on seg_pkg for the sample type.
interface seg_in_if import seg_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface seg_out_if import seg_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### src/seg_ctrl.sv
// Sequencer for the gain stage: steps the datapath through one item and
// owns the input ready and output valid handshake. Depends on seg_pkg.
module seg_ctrl import seg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ENV_MUL = 5'd1;
  localparam logic [4:0] S_ENV_UPD = 5'd2;
  localparam logic [4:0] S_U_MUL   = 5'd3;
  localparam logic [4:0] S_U_UPD   = 5'd4;
  localparam logic [4:0] S_T_MUL   = 5'd5;
  localparam logic [4:0] S_T_UPD   = 5'd6;
  localparam logic [4:0] S_Z_MUL   = 5'd7;
  localparam logic [4:0] S_Z_UPD   = 5'd8;
  localparam logic [4:0] S_TBL     = 5'd9;
  localparam logic [4:0] S_I_MUL   = 5'd10;
  localparam logic [4:0] S_I_UPD   = 5'd11;
  localparam logic [4:0] S_SHAPE   = 5'd12;
  localparam logic [4:0] S_S_MUL   = 5'd13;
  localparam logic [4:0] S_S_UPD   = 5'd14;
  localparam logic [4:0] S_G_MUL   = 5'd15;
  localparam logic [4:0] S_G_UPD   = 5'd16;
  localparam logic [4:0] S_L_MUL   = 5'd17;
  localparam logic [4:0] S_L_UPD   = 5'd18;
  localparam logic [4:0] S_R_MUL   = 5'd19;
  localparam logic [4:0] S_R_UPD   = 5'd20;
  localparam logic [4:0] S_FOL     = 5'd21;
  localparam logic [4:0] S_OUT     = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ENV_MUL;
        end
      end
      S_ENV_MUL: begin cmd.op = OP_ENV_MUL; state_nxt = S_ENV_UPD; end
      S_ENV_UPD: begin cmd.op = OP_ENV_UPD; state_nxt = S_U_MUL;   end
      S_U_MUL:   begin cmd.op = OP_U_MUL;   state_nxt = S_U_UPD;   end
      S_U_UPD:   begin cmd.op = OP_U_UPD;   state_nxt = S_T_MUL;   end
      S_T_MUL:   begin cmd.op = OP_T_MUL;   state_nxt = S_T_UPD;   end
      S_T_UPD:   begin cmd.op = OP_T_UPD;   state_nxt = S_Z_MUL;   end
      S_Z_MUL:   begin cmd.op = OP_Z_MUL;   state_nxt = S_Z_UPD;   end
      S_Z_UPD:   begin cmd.op = OP_Z_UPD;   state_nxt = S_TBL;     end
      S_TBL:     begin cmd.op = OP_TBL;     state_nxt = S_I_MUL;   end
      S_I_MUL:   begin cmd.op = OP_I_MUL;   state_nxt = S_I_UPD;   end
      S_I_UPD:   begin cmd.op = OP_I_UPD;   state_nxt = S_SHAPE;   end
      S_SHAPE:   begin cmd.op = OP_SHAPE;   state_nxt = S_S_MUL;   end
      S_S_MUL:   begin cmd.op = OP_S_MUL;   state_nxt = S_S_UPD;   end
      S_S_UPD: begin
        cmd.op    = OP_S_UPD;
        state_nxt = status.follower ? S_FOL : S_G_MUL;
      end
      S_G_MUL:   begin cmd.op = OP_G_MUL;   state_nxt = S_G_UPD;   end
      S_G_UPD:   begin cmd.op = OP_G_UPD;   state_nxt = S_L_MUL;   end
      S_L_MUL:   begin cmd.op = OP_L_MUL;   state_nxt = S_L_UPD;   end
      S_L_UPD:   begin cmd.op = OP_L_UPD;   state_nxt = S_R_MUL;   end
      S_R_MUL:   begin cmd.op = OP_R_MUL;   state_nxt = S_R_UPD;   end
      S_R_UPD:   begin cmd.op = OP_R_UPD;   state_nxt = S_OUT;     end
      S_FOL:     begin cmd.op = OP_FOL;     state_nxt = S_OUT;     end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/seg_dpath.sv
// Datapath of the gain stage: configuration registers, envelope and gain
// state, one shared multiplier and the exponent table. Depends on seg_pkg.
module seg_dpath import seg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  sample_t               in_left,
  input  sample_t               in_right,
  output sample_t               out_left,
  output sample_t               out_right
);

  // configuration
  q24_t        thr_level_r;
  logic [32:0] thr_gain_r;
  logic [21:0] shape_fac_r;
  q24_t        shape_floor_r;
  q24_t        attack_r;
  q24_t        decay_r;
  logic [19:0] out_level_r;
  logic        follower_r;

  // state
  q24_t env_r;
  q24_t sg_r;

  // working registers
  sample_t             l_r, r_r;
  logic [SAMPLE_W:0]   al_r, ar_r;
  q24_t                lvl_r;
  logic [MP_W-1:0]     prod_r;
  q24_t                u_r;
  logic [30:0]         t_r;
  logic [31:0]         z_r;
  q24_t                lo_r, hi_r, v_r, shaped_r;
  logic [28:0]         g_r;
  sample_t             lres_r, rres_r;
  sample_t             out_left_r, out_right_r;

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;

  logic [SAMPLE_W:0] in_al, in_ar;
  q24_t              lvl_in;
  logic              env_up, sg_up, lo_dn;
  q24_t              env_diff, sg_diff, itp_diff;
  q24_t              atk_c, dec_c;
  logic [MP_W-1:0]   p24, p16;
  q24_t              delta;
  q24_t              env_step;
  logic [7:0]        z_n;
  logic [23:0]       z_f;
  logic [TBL_AW-1:0] tbl_idx, tbl_idx_p1;
  logic [23:0]       tbl_rem;
  logic [5:0]        sh_amt;
  logic [40:0]       sh_rnd, sh_sum, sh_p;
  q24_t              sh_p25, shaped_nxt;
  logic [25:0]       fol_g;
  logic signed [SAT_W-1:0] fol_gw, mag_w;

  assign status.follower = follower_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  // input magnitudes and mean level (sum of magnitudes in Q0.24)
  assign in_al  = in_left[SAMPLE_W-1]  ? ((SAMPLE_W+1)'(0) - {in_left[SAMPLE_W-1], in_left})
                                       : {1'b0, in_left};
  assign in_ar  = in_right[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {in_right[SAMPLE_W-1], in_right})
                                       : {1'b0, in_right};
  assign lvl_in = 25'(in_al + in_ar) << LVL_SH;

  assign atk_c = clamp_rate(attack_r);
  assign dec_c = clamp_rate(decay_r);

  assign env_up   = lvl_r > env_r;
  assign env_diff = env_up ? (lvl_r - env_r) : (env_r - lvl_r);
  assign sg_up    = shaped_r > sg_r;
  assign sg_diff  = sg_up ? (shaped_r - sg_r) : (sg_r - shaped_r);
  assign lo_dn    = lo_r >= hi_r;
  assign itp_diff = lo_dn ? (lo_r - hi_r) : (hi_r - lo_r);

  assign p24   = rnd_shr(prod_r, 24);
  assign p16   = rnd_shr(prod_r, 16);
  assign delta = 25'(p24);

  assign env_step = env_up ? (env_r + delta) : (env_r - delta);

  // exponent split: integer part shifts, fraction indexes the table
  assign z_n        = z_r[31:24];
  assign z_f        = z_r[23:0];
  assign tbl_idx    = z_f[23 -: TBL_AW];
  assign tbl_idx_p1 = tbl_idx + TBL_AW'(1);
  assign tbl_rem    = {z_f[23-TBL_AW:0], {TBL_AW{1'b0}}};

  // rounded right shift by the integer part, then clamp and floor
  assign sh_amt = z_n[5:0];
  assign sh_rnd = (z_n == 8'd0) ? 41'd0 : (41'd1 << (sh_amt - 6'd1));
  assign sh_sum = {16'd0, v_r} + sh_rnd;
  assign sh_p   = (z_n >= 8'd40) ? 41'd0 : (sh_sum >> sh_amt);
  assign sh_p25 = (sh_p > 41'(ONE_Q24)) ? ONE_Q24 : 25'(sh_p);
  assign shaped_nxt = (sh_p25 > shape_floor_r) ? (sh_p25 - shape_floor_r) : 25'd0;

  // follower output: gain scaled to sample format
  assign fol_g  = ({1'b0, sg_r} + (26'd1 << (FOL_SH - 1))) >> FOL_SH;
  assign fol_gw = $signed(SAT_W'(fol_g));
  assign mag_w  = $signed(SAT_W'(p24));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ENV_MUL: begin mul_a = env_up ? atk_c : dec_c; mul_b = MB_W'(env_diff); end
      OP_U_MUL:   begin mul_a = env_r;                  mul_b = thr_gain_r;       end
      OP_T_MUL:   begin mul_a = ONE_Q24 - u_r;          mul_b = MB_W'(shape_fac_r); end
      OP_Z_MUL:   begin mul_a = LOG2E_Q24;              mul_b = MB_W'(t_r);       end
      OP_I_MUL:   begin mul_a = itp_diff;               mul_b = MB_W'(tbl_rem);   end
      OP_S_MUL:   begin mul_a = dec_c;                  mul_b = MB_W'(sg_diff);   end
      OP_G_MUL:   begin mul_a = sg_r;                   mul_b = MB_W'(out_level_r); end
      OP_L_MUL:   begin mul_a = MA_W'(al_r);            mul_b = MB_W'(g_r);       end
      OP_R_MUL:   begin mul_a = MA_W'(ar_r);            mul_b = MB_W'(g_r);       end
      default:    begin mul_a = '0;                     mul_b = '0;               end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= MP_W'(mul_a) * MP_W'(mul_b);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_level_r   <= RST_THR_LEVEL;
      thr_gain_r    <= RST_THR_GAIN;
      shape_fac_r   <= RST_SHAPE_FAC;
      shape_floor_r <= RST_SHAPE_FLOOR;
      attack_r      <= RST_ATTACK;
      decay_r       <= RST_DECAY;
      out_level_r   <= RST_OUT_LEVEL;
      follower_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_THR_LEVEL:   thr_level_r   <= cfg_wdata[24:0];
        REG_THR_GAIN:    thr_gain_r    <= cfg_wdata[32:0];
        REG_SHAPE_FAC:   shape_fac_r   <= cfg_wdata[21:0];
        REG_SHAPE_FLOOR: shape_floor_r <= cfg_wdata[24:0];
        REG_ATTACK:      attack_r      <= cfg_wdata[24:0];
        REG_DECAY:       decay_r       <= cfg_wdata[24:0];
        REG_OUT_LEVEL:   out_level_r   <= cfg_wdata[19:0];
        REG_FOLLOWER:    follower_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // envelope and smoothed gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
      sg_r  <= '0;
    end else begin
      if (cmd.op == OP_ENV_UPD) begin
        env_r <= (env_step > thr_level_r) ? thr_level_r : env_step;
      end
      if (cmd.op == OP_S_UPD) begin
        sg_r <= sg_up ? (sg_r + delta) : (sg_r - delta);
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      l_r   <= in_left;
      r_r   <= in_right;
      al_r  <= in_al;
      ar_r  <= in_ar;
      lvl_r <= lvl_in;
    end
    if (cmd.ld_out) begin
      out_left_r  <= lres_r;
      out_right_r <= rres_r;
    end
    case (cmd.op)
      OP_U_UPD: u_r <= (p16 > MP_W'(ONE_Q24)) ? ONE_Q24 : 25'(p16);
      OP_T_UPD: t_r <= 31'(p16);
      OP_Z_UPD: z_r <= 32'(p24);
      OP_TBL: begin
        lo_r <= POW2_TBL[tbl_idx];
        hi_r <= (tbl_idx == TBL_AW'(TBL_D - 1)) ? POW2_LAST : POW2_TBL[tbl_idx_p1];
      end
      OP_I_UPD: v_r      <= lo_dn ? (lo_r - delta) : (lo_r + delta);
      OP_SHAPE: shaped_r <= shaped_nxt;
      OP_G_UPD: g_r      <= 29'(p16);
      OP_L_UPD: lres_r   <= sat_s(l_r[SAMPLE_W-1] ? -mag_w : mag_w);
      OP_R_UPD: rres_r   <= sat_s(r_r[SAMPLE_W-1] ? -mag_w : mag_w);
      OP_FOL: begin
        lres_r <= sat_s(fol_gw);
        rres_r <= sat_s(SAT_W'(r_r) + fol_gw);
      end
      default: ;
    endcase
  end

endmodule

### src/stereo_expander_gain_stage_top.sv
// Top level of the stereo expander / noise-gate gain stage.
// Depends on seg_pkg, seg_if, seg_ctrl, seg_dpath and the assertion header.
//
// One stereo sample pair in, one processed pair out. The envelope follows
// the mean magnitude of left and right (attack rate when rising, decay rate
// when falling, clamped at the threshold level), is shaped through a base-2
// exponent with a 256-entry fraction table and linear interpolation, and is
// smoothed with the decay rate into the gain. In audio mode each output is
// sample * gain * output level, rounded and saturated; in follower mode
// left carries the gain and right carries right plus the gain. All products
// run through one shared 25x33 multiplier, each registered in a multiply step
// and used in the update step that follows; the sequencer takes a new pair
// only once it is back in idle, and follower mode replaces the gain and output
// multiply steps with a single follower step. The result and its valid are
// loaded in the output state after the last step. The result sits in an output
// register, so the next sample is taken while it waits; a stalled output
// delays only the final load. Configuration writes take effect at once and are
// meant for idle periods; reset restores the documented register defaults and clears envelope and gain.
`include "stereo_expander_gain_stage_top_assert.svh"

module stereo_expander_gain_stage_top import seg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  seg_in_if.sink                in_ch,
  seg_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencer: handshakes and step order
  seg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, state, configuration and output register
  seg_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_left   (in_ch.left_sample),
    .in_right  (in_ch.right_sample),
    .out_left  (out_ch.left_out),
    .out_right (out_ch.right_out)
  );

  // a transfer in never produces a result in the very next cycle
  `SEG_ASSERT_NEXT(a_accept_no_load, in_ch.valid && in_ch.ready, !cmd.ld_out, "result loaded right after transfer in")
  // the output register is only overwritten when empty or draining
  `SEG_ASSERT_NOW(a_load_slot_free, cmd.ld_out, !out_ch.valid || out_ch.ready, "output overwritten while stalled")
  // ready only while no datapath step is running
  `SEG_ASSERT_NOW(a_ready_dp_quiet, in_ch.ready, cmd.op == OP_NONE, "datapath busy while ready")
  // a load always presents a result next cycle
  `SEG_ASSERT_NEXT(a_load_sets_valid, cmd.ld_out, out_ch.valid, "load without valid result")

endmodule

### tb/tb_stereo_expander_gain_stage_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the stereo expander / noise-gate gain stage.
// Depends on seg_pkg, seg_if and the top level; drives stereo pairs, predicts each processed pair.

module tb_stereo_expander_gain_stage_top;
  import seg_pkg::*;

  // Fixed-point constants of the gain law, kept locally for the predictor
  localparam longint unsigned UNITY_Q24  = 64'd16777216;
  localparam longint unsigned FRAC_MASK  = 64'd16777215;
  localparam longint unsigned LOG2_E_Q24 = 64'd24204406;
  localparam longint unsigned LN_2_Q30   = 64'd744261118;
  localparam longint unsigned UNITY_Q30  = 64'd1073741824;
  localparam int              FRAC_STEPS = 256;
  localparam longint          SAMPLE_HI  = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint          SAMPLE_LO  = -SAMPLE_HI - 1;

  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch
  localparam int END_SETTLE     = 50;    // settle time for stray results after the drain
  localparam int PHASE_ITEMS    = 60;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // Shadow of the programmed register file
  typedef struct packed {
    logic [24:0] thr_level;
    logic [32:0] thr_gain;
    logic [21:0] shape;
    logic [24:0] shape_floor;
    logic [24:0] attack;
    logic [24:0] decay;
    logic [19:0] out_level;
    logic        follower;
  } gate_setting_t;

  // Character of a run of program material
  typedef enum int {QUIET_HISS, SOFT_PASSAGE, LOUD_PASSAGE, FULL_SCALE, WHITE_NOISE} burst_kind_t;

  localparam gate_setting_t POWER_ON_SETTING = '{
    thr_level: RST_THR_LEVEL, thr_gain: RST_THR_GAIN, shape: RST_SHAPE_FAC,
    shape_floor: RST_SHAPE_FLOOR, attack: RST_ATTACK, decay: RST_DECAY,
    out_level: RST_OUT_LEVEL, follower: 1'b0};

  localparam gate_setting_t ALL_MAX_SETTING = '{
    thr_level: 25'h100_0000, thr_gain: 33'h1_FFFF_FFFF, shape: 22'h3F_FFFF,
    shape_floor: 25'h100_0000, attack: 25'h100_0000, decay: 25'h100_0000,
    out_level: 20'hF_FFFF, follower: 1'b1};

  localparam gate_setting_t ALL_MIN_SETTING = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  seg_in_if  in_bus ();
  seg_out_if out_bus ();

  stereo_expander_gain_stage_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state: register shadow, envelope, smoothed gain, 2^-x table
  gate_setting_t     live;
  longint unsigned   env_q24;
  longint unsigned   gain_q24;
  longint unsigned   exp2_frac [0:FRAC_STEPS];

  stereo_pair_t      pending_pairs [$];   // stimulus not yet offered
  stereo_pair_t      expected_pairs [$];  // predicted results, oldest first
  stereo_pair_t      staged_pair;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_request = 1'b0;
  bit          rx_hold = 1'b0;
  int          mismatches = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Gain law arithmetic
  // ---------------------------------------------------------------------------

  // Shift right with round half up; shifts past the word give zero
  function automatic longint unsigned rnd_shift(input longint unsigned v, input int unsigned s);
    if (s == 0) return v;
    if (s >= 63) return 0;
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic longint unsigned limit_rate(input longint unsigned r);
    return (r > UNITY_Q24) ? UNITY_Q24 : r;
  endfunction

  // One-pole step of cur toward target, rate in Q0.24
  function automatic longint unsigned move_toward(input longint unsigned cur,
                                                  input longint unsigned target,
                                                  input longint unsigned rate);
    if (target > cur) return cur + rnd_shift(rate * (target - cur), 24);
    return cur - rnd_shift(rate * (cur - target), 24);
  endfunction

  function automatic sample_t clip_sample(input longint v);
    if (v > SAMPLE_HI) return sample_t'(SAMPLE_HI);
    if (v < SAMPLE_LO) return sample_t'(SAMPLE_LO);
    return sample_t'(v);
  endfunction

  // sample * gain (Q.24), magnitude rounded, sign restored
  function automatic longint apply_gain(input longint smp, input longint unsigned g);
    longint unsigned mag;
    longint          prod;
    mag  = (smp < 0) ? -smp : smp;
    prod = longint'(rnd_shift(mag * g, 24));
    return (smp < 0) ? -prod : prod;
  endfunction

  // Table of 2^(-k/FRAC_STEPS) in Q0.24, from a 16-term e^-a series in Q2.30
  function automatic void fill_exp2_frac();
    longint unsigned x;
    longint unsigned a;
    longint unsigned term;
    longint unsigned acc;
    int              k;
    int              n;
    for (k = 0; k <= FRAC_STEPS; k++) begin
      x    = (64'(k) << 30) / 64'(FRAC_STEPS);
      a    = rnd_shift(x * LN_2_Q30, 30);
      term = UNITY_Q30;
      acc  = UNITY_Q30;
      for (n = 1; n <= 16; n++) begin
        term = ((term * a) >> 30) / 64'(n);
        if (n % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
      exp2_frac[k] = rnd_shift(acc, 6);
    end
  endfunction

  // exp(shape * (env * thr_gain - 1)) - floor, via 2^-z with table interpolation
  function automatic longint unsigned shaped_gain(input longint unsigned env);
    longint unsigned u;
    longint unsigned t;
    longint unsigned z;
    longint unsigned whole;
    longint unsigned fd;
    longint unsigned idx;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned v;
    longint unsigned p;
    u = rnd_shift(env * live.thr_gain, 16);
    if (u > UNITY_Q24) u = UNITY_Q24;  // exponent never positive
    t     = rnd_shift(live.shape * (UNITY_Q24 - u), 16);
    z     = rnd_shift(t * LOG2_E_Q24, 24);
    whole = z >> 24;
    fd    = (z & FRAC_MASK) * FRAC_STEPS;
    idx   = fd >> 24;
    if (idx > FRAC_STEPS - 1) idx = FRAC_STEPS - 1;
    rem = fd & FRAC_MASK;
    lo  = exp2_frac[idx];
    hi  = exp2_frac[idx + 1];
    if (lo >= hi) v = lo - rnd_shift((lo - hi) * rem, 24);
    else          v = lo + rnd_shift((hi - lo) * rem, 24);
    p = (whole >= 40) ? 0 : rnd_shift(v, int'(whole));
    if (p > UNITY_Q24) p = UNITY_Q24;
    return (p > live.shape_floor) ? p - live.shape_floor : 0;
  endfunction

  // Advance envelope and smoothed gain by one stereo pair, return the output pair
  function automatic stereo_pair_t process_sample_pair(input sample_t l_in, input sample_t r_in);
    longint          sl;
    longint          sr;
    longint          g_signal;
    longint unsigned level;
    longint unsigned rate;
    longint unsigned g;
    stereo_pair_t    res;
    sl    = l_in;
    sr    = r_in;
    level = longint'(((sl < 0) ? -sl : sl) + ((sr < 0) ? -sr : sr)) << LVL_SH;
    rate  = (level > env_q24) ? limit_rate(live.attack) : limit_rate(live.decay);
    env_q24 = move_toward(env_q24, level, rate);
    if (env_q24 > live.thr_level) env_q24 = live.thr_level;
    gain_q24 = move_toward(gain_q24, shaped_gain(env_q24), limit_rate(live.decay));
    if (live.follower) begin
      g_signal  = longint'(rnd_shift(gain_q24, FOL_SH));
      res.left  = clip_sample(g_signal);
      res.right = clip_sample(sr + g_signal);
    end else begin
      g         = rnd_shift(gain_q24 * live.out_level, 16);
      res.left  = clip_sample(apply_gain(sl, g));
      res.right = clip_sample(apply_gain(sr, g));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sample_t draw_sample(input burst_kind_t kind);
    int unsigned mag;
    mag = 0;
    case (kind)
      QUIET_HISS:   mag = $urandom_range(3);
      SOFT_PASSAGE: mag = $urandom_range(1024);
      LOUD_PASSAGE: mag = $urandom_range(32767, 8192);
      FULL_SCALE:   return $urandom_range(1) ? sample_t'(SAMPLE_HI) : sample_t'(SAMPLE_LO);
      default:      return sample_t'($urandom());
    endcase
    return $urandom_range(1) ? sample_t'(-int'(mag)) : sample_t'(mag);
  endfunction

  function automatic burst_kind_t draw_kind();
    case ($urandom_range(9))
      0, 1:    return QUIET_HISS;
      2, 3:    return SOFT_PASSAGE;
      4, 5, 6: return LOUD_PASSAGE;
      7:       return FULL_SCALE;
      default: return WHITE_NOISE;
    endcase
  endfunction

  function automatic logic [24:0] draw_rate();
    case ($urandom_range(3))
      0:       return 25'($urandom_range(32'h100_0000, 32'h4_0000));
      1:       return 25'h100_0000;
      2:       return 25'($urandom());  // may land above unity
      default: return 25'($urandom_range(32'h1_0000));
    endcase
  endfunction

  function automatic gate_setting_t draw_setting();
    gate_setting_t   s;
    longint unsigned recip;
    case ($urandom_range(3))
      0:       s.thr_level = 25'h100_0000;
      1:       s.thr_level = 25'($urandom_range(32'h100_0000));
      2:       s.thr_level = 25'($urandom_range(32'h100_0000, 32'h10_0000));
      default: s.thr_level = 25'($urandom_range(32'h4_0000));
    endcase
    recip = (s.thr_level == 0) ? 64'h1_FFFF_FFFF : (64'd1 << 40) / s.thr_level;
    if (recip > 64'h1_FFFF_FFFF) recip = 64'h1_FFFF_FFFF;
    case ($urandom_range(3))
      0:       s.thr_gain = 33'(recip);
      1:       s.thr_gain = 33'({$urandom(), $urandom()});
      2:       s.thr_gain = 33'(65536 + $urandom_range(4096));
      default: s.thr_gain = $urandom_range(1) ? 33'h1_FFFF_FFFF : 33'd0;
    endcase
    case ($urandom_range(2))
      0:       s.shape = 22'($urandom());
      1:       s.shape = 22'($urandom_range(32'h8_0000));
      default: s.shape = $urandom_range(1) ? 22'h3F_FFFF : 22'd0;
    endcase
    case ($urandom_range(3))
      0:       s.shape_floor = 25'd0;
      1:       s.shape_floor = 25'($urandom_range(32'h40_0000));
      2:       s.shape_floor = 25'($urandom_range(32'h100_0000));
      default: s.shape_floor = 25'h100_0000;
    endcase
    s.attack = draw_rate();
    s.decay  = draw_rate();
    case ($urandom_range(3))
      0:       s.out_level = 20'd65536;
      1:       s.out_level = 20'($urandom());
      2:       s.out_level = 20'hF_FFFF;
      default: s.out_level = 20'($urandom_range(32'h4_0000));
    endcase
    s.follower = 1'($urandom_range(1));
    return s;
  endfunction

  // Queue program material: runs of similar level, so the envelope can
  // build up and fall away, mixed with stretches of white noise
  task automatic queue_program_material(input int count);
    int          left_to_go;
    int          run;
    int          i;
    burst_kind_t kind;
    left_to_go = count;
    while (left_to_go > 0) begin
      run  = $urandom_range(16, 1);
      if (run > left_to_go) run = left_to_go;
      kind = draw_kind();
      for (i = 0; i < run; i++)
        pending_pairs.push_back('{left: draw_sample(kind), right: draw_sample(kind)});
      left_to_go -= run;
    end
  endtask

  task automatic push_pair(input longint l, input longint r);
    pending_pairs.push_back('{left: sample_t'(l), right: sample_t'(r)});
  endtask

  // Block until every queued pair has been transferred and answered
  task automatic wait_idle();
    @(negedge clk);
    while (pending_pairs.size() != 0 || expected_pairs.size() != 0 || in_bus.valid)
      @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Write one register; junk above the register width must be dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] data;
    data = value;
    if (width < CFG_DATA_W && $urandom_range(1) == 1)
      data = data | CFG_DATA_W'({$urandom(), $urandom()} << width);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_THR_LEVEL:   live.thr_level   = data[24:0];
      REG_THR_GAIN:    live.thr_gain    = data[32:0];
      REG_SHAPE_FAC:   live.shape       = data[21:0];
      REG_SHAPE_FLOOR: live.shape_floor = data[24:0];
      REG_ATTACK:      live.attack      = data[24:0];
      REG_DECAY:       live.decay       = data[24:0];
      REG_OUT_LEVEL:   live.out_level   = data[19:0];
      REG_FOLLOWER:    live.follower    = data[0];
      default: ;
    endcase
  endtask

  // Program the whole register file; call only with the block idle
  task automatic apply_setting(input gate_setting_t s);
    write_reg(REG_THR_LEVEL,   CFG_DATA_W'(s.thr_level),   $bits(s.thr_level));
    write_reg(REG_THR_GAIN,    CFG_DATA_W'(s.thr_gain),    $bits(s.thr_gain));
    write_reg(REG_SHAPE_FAC,   CFG_DATA_W'(s.shape),       $bits(s.shape));
    write_reg(REG_SHAPE_FLOOR, CFG_DATA_W'(s.shape_floor), $bits(s.shape_floor));
    write_reg(REG_ATTACK,      CFG_DATA_W'(s.attack),      $bits(s.attack));
    write_reg(REG_DECAY,       CFG_DATA_W'(s.decay),       $bits(s.decay));
    write_reg(REG_OUT_LEVEL,   CFG_DATA_W'(s.out_level),   $bits(s.out_level));
    write_reg(REG_FOLLOWER,    CFG_DATA_W'(s.follower),    $bits(s.follower));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: hold valid until the transfer, predict on every transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      // Predict from the pair that moved on this edge
      if (in_bus.valid && in_bus.ready)
        expected_pairs.push_back(process_sample_pair(in_bus.left_sample, in_bus.right_sample));
      // Offer the next pair only once the slot is free
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          staged_pair          = pending_pairs.pop_front();
          in_bus.left_sample  <= staged_pair.left;
          in_bus.right_sample <= staged_pair.right;
          in_bus.valid        <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result L=%0d R=%0d with nothing pending",
                     out_bus.left_out, out_bus.right_out);
        end else begin
          staged_pair = expected_pairs.pop_front();
          if (out_bus.left_out !== staged_pair.left || out_bus.right_out !== staged_pair.right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                       staged_pair.left, staged_pair.right, out_bus.left_out, out_bus.right_out);
          end
        end
      end
      out_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the output register
  // fills, the block finishes the next pair and then stalls its input
  initial begin
    wait (hold_request);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    gate_setting_t s;
    int            phase;

    in_bus.valid        = 1'b0;
    in_bus.left_sample  = '0;
    in_bus.right_sample = '0;
    out_bus.ready       = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_THR_LEVEL;
    cfg_wdata           = '0;
    fill_exp2_frac();
    live     = POWER_ON_SETTING;
    env_q24  = 0;
    gain_q24 = 0;
    set_idling(24, 78);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Power-on registers: full-scale corners and silence
    push_pair(SAMPLE_HI, SAMPLE_HI);
    push_pair(SAMPLE_LO, SAMPLE_LO);
    push_pair(0, 0);
    push_pair(-1, 1);
    push_pair(SAMPLE_HI, SAMPLE_LO);
    push_pair(0, SAMPLE_LO);
    wait_idle();

    // Attack above unity, envelope times gain above one, make-up gain at max:
    // the gain snaps open and the audio path saturates
    s = '{thr_level: 25'h100_0000, thr_gain: 33'h1_FFFF_FFFF, shape: 22'd262144,
          shape_floor: 25'd0, attack: 25'h1FF_FFFF, decay: 25'h100_0000,
          out_level: 20'hF_FFFF, follower: 1'b0};
    apply_setting(s);
    push_pair(SAMPLE_HI, SAMPLE_LO);
    push_pair(SAMPLE_LO, SAMPLE_HI);
    push_pair(0, 0);
    push_pair(16384, -16384);
    push_pair(SAMPLE_LO, SAMPLE_LO);
    push_pair(1, -1);
    wait_idle();

    // Follower mode with the floor at unity: shaped envelope stays at zero
    s = '{thr_level: 25'h100_0000, thr_gain: 33'd65536, shape: 22'd65536,
          shape_floor: 25'h100_0000, attack: 25'h100_0000, decay: 25'h80_0000,
          out_level: 20'd65536, follower: 1'b1};
    apply_setting(s);
    push_pair(SAMPLE_HI, SAMPLE_HI);
    push_pair(SAMPLE_LO, SAMPLE_HI);
    push_pair(0, SAMPLE_LO);
    push_pair(100, -100);
    wait_idle();

    // Zero threshold gain and steepest shape: exponent integer part far past
    // the shift range, so the gain collapses to zero
    s = '{thr_level: 25'h100_0000, thr_gain: 33'd0, shape: 22'h3F_FFFF,
          shape_floor: 25'd0, attack: 25'h100_0000, decay: 25'h100_0000,
          out_level: 20'd65536, follower: 1'b0};
    apply_setting(s);
    push_pair(SAMPLE_HI, SAMPLE_LO);
    push_pair(SAMPLE_LO, SAMPLE_HI);
    push_pair(12345, -12345);
    push_pair(0, 0);
    wait_idle();

    // Random phases: each with a fresh register set; idling swapped at phase three, zero for the last two
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 3)      set_idling(24, 78);
      else if (phase < 6) set_idling(78, 24);
      else                set_idling(0, 0);

      if (phase == 0)      s = ALL_MAX_SETTING;
      else if (phase == 3) s = ALL_MIN_SETTING;
      else                 s = draw_setting();
      apply_setting(s);

      if (phase == 4) begin
        // Stop feeding until every pending result is back, then resume
        queue_program_material(PHASE_ITEMS / 2);
        wait_idle();
        queue_program_material(PHASE_ITEMS / 2);
      end else if (phase == 6) begin
        queue_program_material(PHASE_ITEMS);
        hold_request = 1'b1;
      end else begin
        queue_program_material(PHASE_ITEMS);
      end
      wait_idle();
    end

    // Drain, then give stray results time to show up
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (expected_pairs.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
